/* src/tpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tpc_pkg;

    localparam int RAW_W    = 10;
    localparam int SIZE_W   = 12;
    localparam int TW_W     = 19;
    localparam int TGT_W    = 12;
    localparam int DS_W     = RAW_W + 1;
    localparam int DT_W     = TGT_W + 1;
    localparam int G_W      = RAW_W + TGT_W + 1;
    localparam int CX_W     = G_W + DS_W;
    localparam int CF_W     = 26;
    localparam int CN_W     = 38;
    localparam int DIV_W    = 24;
    localparam int PR_W     = CF_W + DS_W;
    localparam int NUM_W    = 40;
    localparam int Q_W      = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int HOLD_W   = 3;
    localparam int COEF_LAT = 6;
    localparam int RECIP_W  = 20;
    localparam int RECIP_SH = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

    localparam logic [6:0] PCT_15 = 7'd15;
    localparam logic [6:0] PCT_50 = 7'd50;
    localparam logic [6:0] PCT_55 = 7'd55;
    localparam logic [6:0] PCT_85 = 7'd85;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_D0X    = 3'd2,
        REG_D0Y    = 3'd3,
        REG_D1X    = 3'd4,
        REG_D1Y    = 3'd5,
        REG_D2X    = 3'd6,
        REG_D2Y    = 3'd7
    } t_reg;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } t_in;

    typedef struct packed {
        logic [Q_W-1:0] out_x;
        logic [Q_W-1:0] out_y;
        logic           calibrated;
    } t_out;

    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [RAW_W-1:0]  d0x;
        logic [RAW_W-1:0]  d0y;
        logic [RAW_W-1:0]  d1x;
        logic [RAW_W-1:0]  d1y;
        logic [RAW_W-1:0]  d2x;
        logic [RAW_W-1:0]  d2y;
    } t_cfg;

    typedef struct packed {
        logic signed [CF_W-1:0]  an;
        logic signed [CF_W-1:0]  bn;
        logic signed [CN_W-1:0]  cn;
        logic signed [CF_W-1:0]  dn;
        logic signed [CF_W-1:0]  en;
        logic signed [CN_W-1:0]  fn;
        logic signed [DIV_W-1:0] div;
    } t_coef;

    typedef struct packed {
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
        logic             zx;
        logic             zy;
        logic             sx;
        logic             sy;
        logic             pass;
        t_in              raw;
        logic [DIV_W-1:0] d;
    } t_dv;

    function automatic logic [TGT_W-1:0] div100(input logic [TW_W-1:0] v);
        logic [TW_W+RECIP_W-1:0] p;
        p = TW_W'(v) * RECIP_100;
        return p[RECIP_SH+TGT_W-1:RECIP_SH];
    endfunction

endpackage
`default_nettype wire

/* src/tpc_coef.sv */
`timescale 1ns / 1ps
`default_nettype none
module tpc_coef import tpc_pkg::*; (
    input  logic  i_clk,
    input  t_cfg  i_cfg,
    output t_coef o_coef
);

    logic [TW_W-1:0] r_twx0, r_twx1, r_twx2, r_twy0, r_twy1, r_twy2;
    logic [TGT_W-1:0] r_tx0, r_tx1, r_tx2, r_ty0, r_ty1, r_ty2;
    logic signed [DT_W-1:0] r_dtx02, r_dtx12, r_dty02, r_dty12;
    logic signed [G_W-1:0] r_gx0, r_gx1, r_gx2, r_gy0, r_gy1, r_gy2;
    logic signed [CX_W-1:0] r_cx0, r_cx1, r_cx2, r_cy0, r_cy1, r_cy2;
    logic signed [CF_W-1:0] r_an, r_bn, r_dn, r_en;
    logic signed [DIV_W-1:0] r_div;
    t_coef r_coef;

    logic signed [DS_W-1:0] sx0, sx1, sx2, sy0, sy1, sy2;
    logic signed [DS_W-1:0] dsx02, dsx12, dsy02, dsy12;
    logic signed [DT_W-1:0] tx0, tx1, tx2, ty0, ty1, ty2;

    assign sx0 = {1'b0, i_cfg.d0x};
    assign sx1 = {1'b0, i_cfg.d1x};
    assign sx2 = {1'b0, i_cfg.d2x};
    assign sy0 = {1'b0, i_cfg.d0y};
    assign sy1 = {1'b0, i_cfg.d1y};
    assign sy2 = {1'b0, i_cfg.d2y};
    assign dsx02 = sx0 - sx2;
    assign dsx12 = sx1 - sx2;
    assign dsy02 = sy0 - sy2;
    assign dsy12 = sy1 - sy2;
    assign tx0 = {1'b0, r_tx0};
    assign tx1 = {1'b0, r_tx1};
    assign tx2 = {1'b0, r_tx2};
    assign ty0 = {1'b0, r_ty0};
    assign ty1 = {1'b0, r_ty1};
    assign ty2 = {1'b0, r_ty2};

    always_ff @(posedge i_clk) begin
        r_twx0 <= TW_W'(i_cfg.w) * TW_W'(PCT_15);
        r_twx1 <= TW_W'(i_cfg.w) * TW_W'(PCT_50);
        r_twx2 <= TW_W'(i_cfg.w) * TW_W'(PCT_85);
        r_twy0 <= TW_W'(i_cfg.h) * TW_W'(PCT_15);
        r_twy1 <= TW_W'(i_cfg.h) * TW_W'(PCT_85);
        r_twy2 <= TW_W'(i_cfg.h) * TW_W'(PCT_55);

        r_tx0 <= div100(r_twx0);
        r_tx1 <= div100(r_twx1);
        r_tx2 <= div100(r_twx2);
        r_ty0 <= div100(r_twy0);
        r_ty1 <= div100(r_twy1);
        r_ty2 <= div100(r_twy2);

        r_dtx02 <= tx0 - tx2;
        r_dtx12 <= tx1 - tx2;
        r_dty02 <= ty0 - ty2;
        r_dty12 <= ty1 - ty2;
        r_gx0   <= sx2 * tx1 - sx1 * tx2;
        r_gx1   <= sx0 * tx2 - sx2 * tx0;
        r_gx2   <= sx1 * tx0 - sx0 * tx1;
        r_gy0   <= sx2 * ty1 - sx1 * ty2;
        r_gy1   <= sx0 * ty2 - sx2 * ty0;
        r_gy2   <= sx1 * ty0 - sx0 * ty1;

        r_div <= dsx02 * dsy12 - dsx12 * dsy02;
        r_an  <= r_dtx02 * dsy12 - r_dtx12 * dsy02;
        r_bn  <= dsx02 * r_dtx12 - r_dtx02 * dsx12;
        r_dn  <= r_dty02 * dsy12 - r_dty12 * dsy02;
        r_en  <= dsx02 * r_dty12 - r_dty02 * dsx12;
        r_cx0 <= r_gx0 * sy0;
        r_cx1 <= r_gx1 * sy1;
        r_cx2 <= r_gx2 * sy2;
        r_cy0 <= r_gy0 * sy0;
        r_cy1 <= r_gy1 * sy1;
        r_cy2 <= r_gy2 * sy2;

        r_coef.an  <= r_an;
        r_coef.bn  <= r_bn;
        r_coef.dn  <= r_dn;
        r_coef.en  <= r_en;
        r_coef.div <= r_div;
        r_coef.cn  <= CN_W'(r_cx0) + CN_W'(r_cx1) + CN_W'(r_cx2);
        r_coef.fn  <= CN_W'(r_cy0) + CN_W'(r_cy1) + CN_W'(r_cy2);
    end

    assign o_coef = r_coef;

endmodule
`default_nettype wire

/* src/tpc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module tpc_datapath import tpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_load,
    input  t_in   i_data,
    input  t_coef i_coef,
    output logic  o_valid,
    output t_out  o_data
);

    logic r_v1, r_v2;
    logic signed [PR_W-1:0] r_pax, r_pby, r_pdx, r_pey;
    logic signed [NUM_W-1:0] r_nx, r_ny;
    t_in  r_raw1, r_raw2;
    logic r_pass2;
    logic [Q_W:0] r_sv;
    t_dv  r_dv [Q_W+1];
    logic r_vout;
    t_out r_out;

    logic signed [DS_W-1:0] w_x, w_y;
    t_dv  n_dv0;
    t_out n_out;
    logic [DIV_W-1:0] w_d;

    assign w_x = {1'b0, i_data.raw_x};
    assign w_y = {1'b0, i_data.raw_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_sv   <= '0;
            r_vout <= 1'b0;
        end else if (i_adv) begin
            r_v1   <= i_load;
            r_v2   <= r_v1;
            r_sv   <= {r_sv[Q_W-1:0], r_v2};
            r_vout <= r_sv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pax   <= i_coef.an * w_x;
            r_pby   <= i_coef.bn * w_y;
            r_pdx   <= i_coef.dn * w_x;
            r_pey   <= i_coef.en * w_y;
            r_raw1  <= i_data;
            r_nx    <= NUM_W'(r_pax) + NUM_W'(r_pby) + NUM_W'(i_coef.cn);
            r_ny    <= NUM_W'(r_pdx) + NUM_W'(r_pey) + NUM_W'(i_coef.fn);
            r_raw2  <= r_raw1;
            r_pass2 <= (i_coef.div == '0);
            r_dv[0] <= n_dv0;
            r_out   <= n_out;
        end
    end

    always_comb begin
        w_d = i_coef.div[DIV_W-1] ? DIV_W'(-i_coef.div) : DIV_W'(i_coef.div);
        n_dv0       = '0;
        n_dv0.d     = w_d;
        n_dv0.raw   = r_raw2;
        n_dv0.pass  = r_pass2;
        n_dv0.zx    = r_nx[NUM_W-1] != i_coef.div[DIV_W-1];
        n_dv0.zy    = r_ny[NUM_W-1] != i_coef.div[DIV_W-1];
        n_dv0.rem_x = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
        n_dv0.rem_y = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
        n_dv0.sx    = (n_dv0.rem_x >> Q_W) >= NUM_W'(w_d);
        n_dv0.sy    = (n_dv0.rem_y >> Q_W) >= NUM_W'(w_d);
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int B = Q_W - 1 - k;
        t_dv n_st;
        logic [NUM_W-1:0] dsh;
        always_comb begin
            dsh  = NUM_W'(r_dv[k].d) << B;
            n_st = r_dv[k];
            if (r_dv[k].rem_x >= dsh) begin
                n_st.rem_x  = r_dv[k].rem_x - dsh;
                n_st.q_x[B] = 1'b1;
            end
            if (r_dv[k].rem_y >= dsh) begin
                n_st.rem_y  = r_dv[k].rem_y - dsh;
                n_st.q_y[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dv[k+1] <= n_st;
            end
        end
    end

    always_comb begin
        n_out.calibrated = !r_dv[Q_W].pass;
        if (r_dv[Q_W].pass) begin
            n_out.out_x = Q_W'(r_dv[Q_W].raw.raw_x);
            n_out.out_y = Q_W'(r_dv[Q_W].raw.raw_y);
        end else begin
            n_out.out_x = r_dv[Q_W].zx ? '0 : (r_dv[Q_W].sx ? '1 : r_dv[Q_W].q_x);
            n_out.out_y = r_dv[Q_W].zy ? '0 : (r_dv[Q_W].sy ? '1 : r_dv[Q_W].q_y);
        end
    end

    assign o_valid = r_vout;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* src/touch_three_point_calibration.sv */
// Three-point touch calibration: maps each raw (x, y) sample to screen
// coordinates with the affine transform built from the three measured
// calibration points and the screen size, each result truncated toward zero
// and clamped to 0..65535; a degenerate point set passes the raw sample
// through with calibrated low. One sample is taken every cycle while o_stall
// is low; each sample passes through the multiply, sum and sign stages, the
// 16-step restoring divider and the output register. After reset and after
// every register write the input is stalled while the coefficient pipeline
// recomputes.
`timescale 1ns / 1ps
`default_nettype none
module touch_three_point_calibration import tpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg r_cfg;
    logic [HOLD_W-1:0] r_hold;
    logic w_wr, w_adv, w_load;
    t_reg w_idx;
    t_coef w_coef;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.w   <= SIZE_W'(320);
            r_cfg.h   <= SIZE_W'(240);
            r_cfg.d0x <= '0;
            r_cfg.d0y <= '0;
            r_cfg.d1x <= '0;
            r_cfg.d1y <= '0;
            r_cfg.d2x <= '0;
            r_cfg.d2y <= '0;
            r_hold    <= HOLD_W'(COEF_LAT);
        end else begin
            if (w_wr) begin
                r_hold <= HOLD_W'(COEF_LAT);
                case (w_idx)
                    REG_WIDTH:  r_cfg.w   <= pwdata[SIZE_W-1:0];
                    REG_HEIGHT: r_cfg.h   <= pwdata[SIZE_W-1:0];
                    REG_D0X:    r_cfg.d0x <= pwdata[RAW_W-1:0];
                    REG_D0Y:    r_cfg.d0y <= pwdata[RAW_W-1:0];
                    REG_D1X:    r_cfg.d1x <= pwdata[RAW_W-1:0];
                    REG_D1Y:    r_cfg.d1y <= pwdata[RAW_W-1:0];
                    REG_D2X:    r_cfg.d2x <= pwdata[RAW_W-1:0];
                    REG_D2Y:    r_cfg.d2y <= pwdata[RAW_W-1:0];
                    default:    r_cfg     <= r_cfg;
                endcase
            end else if (r_hold != '0) begin
                r_hold <= r_hold - 1'b1;
            end
        end
    end

    always_comb begin
        case (w_idx)
            REG_WIDTH:  prdata = DATA_W'(r_cfg.w);
            REG_HEIGHT: prdata = DATA_W'(r_cfg.h);
            REG_D0X:    prdata = DATA_W'(r_cfg.d0x);
            REG_D0Y:    prdata = DATA_W'(r_cfg.d0y);
            REG_D1X:    prdata = DATA_W'(r_cfg.d1x);
            REG_D1Y:    prdata = DATA_W'(r_cfg.d1y);
            REG_D2X:    prdata = DATA_W'(r_cfg.d2x);
            REG_D2Y:    prdata = DATA_W'(r_cfg.d2y);
            default:    prdata = '0;
        endcase
    end

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv || (r_hold != '0);
    assign w_load  = i_valid && !o_stall;

    tpc_coef u_coef (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .o_coef (w_coef)
    );

    tpc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_load  (w_load),
        .i_data  (i_data),
        .i_coef  (w_coef),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_wr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !(i_valid && !o_stall))
        else $error("transaction accepted right after register write");

    a_pass_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.calibrated) |->
            (o_data.out_x[Q_W-1:RAW_W] == '0 && o_data.out_y[Q_W-1:RAW_W] == '0))
        else $error("passthrough result out of raw range");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && r_hold == '0) |-> (o_valid && i_stall))
        else $error("input stalled without cause");

endmodule
`default_nettype wire
